// ===== design/qsrq_pkg.sv =====
package qsrq_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned IDX_W   = 6;
   localparam int unsigned RANGE_W = 2 * IDX_W;

   // One range of the work queue, packed start then end.
   typedef struct packed {
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
   } range_type;

   // Datapath operations, selected by the controller from its state.
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_SORT_INIT,
      OP_POP,
      OP_RANGE,
      OP_RD_PIVOT,
      OP_CAPT_PIVOT,
      OP_SCAN_RD,
      OP_SCAN_CMP,
      OP_SWAP_WR,
      OP_SWAP_MK,
      OP_FIN_RD,
      OP_FIN_WR,
      OP_PUSH,
      OP_OUT_RD,
      OP_OUT_SHOW
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic       queue_empty;
      logic       range_short;
      logic       scan_done;
      logic       scan_le;
      logic       push_done;
      logic       out_last;
      logic       count_small;
      logic       count_zero;
   } status_type;

endpackage

// ===== design/qsrq_if.sv =====
interface qsrq_if #(
   parameter int unsigned W = 33
) ();
   logic         valid;
   logic         ready;
   logic [W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/qsrq_ram.sv =====
module qsrq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== design/qsrq_datapath.sv =====
module qsrq_datapath #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  qsrq_pkg::cmd_type             cmd,
   output qsrq_pkg::status_type          status,
   input  logic [qsrq_pkg::VALUE_W-1:0]  in_value,
   output logic [qsrq_pkg::VALUE_W-1:0]  out_value,
   output logic                          out_last,
   output logic                          out_overflow
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [CW-1:0]                 count_ff, count_in;
   logic                          ovf_ff, ovf_in;
   logic [qsrq_pkg::IDX_W-1:0]    head_ff, head_in;
   logic [qsrq_pkg::IDX_W:0]      fill_ff, fill_in;
   logic [qsrq_pkg::IDX_W-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic [qsrq_pkg::IDX_W-1:0]    k_ff, k_in, mark_ff, mark_in;
   logic [qsrq_pkg::VALUE_W-1:0]  pivot_ff, pivot_in;
   logic [qsrq_pkg::VALUE_W-1:0]  hold_ff, hold_in;
   logic [qsrq_pkg::VALUE_W-1:0]  outv_ff, outv_in;
   logic                          outl_ff, outl_in;
   logic                          outo_ff, outo_in;
   logic                          push_sel_ff, push_sel_in;

   logic                          e_we;
   logic [AW-1:0]                 e_wa, e_ra;
   logic [qsrq_pkg::VALUE_W-1:0]  e_wd, e_rd;
   logic                          q_we;
   logic [qsrq_pkg::IDX_W-1:0]    q_wa, q_ra;
   qsrq_pkg::range_type           q_wd, q_rd;

   qsrq_ram #(.WIDTH(qsrq_pkg::VALUE_W), .DEPTH(DEPTH)) u_elem (
      .clock(clock), .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd),
      .rd_addr(e_ra), .rd_data(e_rd));

   qsrq_ram #(.WIDTH(qsrq_pkg::RANGE_W), .DEPTH(64)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(q_ra), .rd_data(q_rd));

   logic                          le;
   logic                          push_a_ok, push_b_ok;
   logic                          last_now;
   logic [qsrq_pkg::IDX_W-1:0]    count_idx;

   assign le = $signed(e_rd) <= $signed(pivot_ff);
   assign count_idx = qsrq_pkg::IDX_W'(count_ff - CW'(1));
   assign push_a_ok = (mark_ff > lo_ff) && ((mark_ff - 6'd1) > lo_ff);
   assign push_b_ok = hi_ff > (mark_ff + 6'd1) && mark_ff != 6'd63;
   assign last_now = (CW'(k_ff) + CW'(1)) == count_ff;

   always_comb begin
      count_in = count_ff;
      ovf_in = ovf_ff;
      head_in = head_ff;
      fill_in = fill_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      k_in = k_ff;
      mark_in = mark_ff;
      pivot_in = pivot_ff;
      hold_in = hold_ff;
      outv_in = outv_ff;
      outl_in = outl_ff;
      outo_in = outo_ff;
      push_sel_in = push_sel_ff;
      e_we = 1'b0;
      e_wa = AW'(k_ff);
      e_wd = in_value;
      e_ra = AW'(k_ff);
      q_we = 1'b0;
      q_wa = head_ff + fill_ff[qsrq_pkg::IDX_W-1:0];
      q_wd = '{lo: lo_ff, hi: hi_ff};
      q_ra = head_ff;
      unique case (cmd.op)
         qsrq_pkg::OP_LOAD: begin
            if (count_ff < CW'(DEPTH)) begin
               e_we = 1'b1;
               e_wa = AW'(count_ff);
               count_in = count_ff + CW'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
         qsrq_pkg::OP_SORT_INIT: begin
            head_in = '0;
            q_we = 1'b1;
            q_wa = '0;
            q_wd = '{lo: '0, hi: count_idx};
            fill_in = 7'd1;
            k_in = '0;
         end
         qsrq_pkg::OP_POP: begin
            // The output pass starts from index zero once the queue drains.
            q_ra = head_ff;
            k_in = '0;
         end
         qsrq_pkg::OP_RANGE: begin
            lo_in = q_rd.lo;
            hi_in = q_rd.hi;
            k_in = q_rd.lo;
            mark_in = q_rd.lo;
            head_in = head_ff + 6'd1;
            fill_in = fill_ff - 7'd1;
         end
         qsrq_pkg::OP_RD_PIVOT: begin
            e_ra = AW'(hi_ff);
         end
         qsrq_pkg::OP_CAPT_PIVOT: begin
            pivot_in = e_rd;
            e_ra = AW'(k_ff);
         end
         qsrq_pkg::OP_SCAN_RD: begin
            e_ra = AW'(k_ff);
         end
         qsrq_pkg::OP_SCAN_CMP: begin
            hold_in = e_rd;
            e_ra = AW'(mark_ff);
            if (!le) begin
               k_in = k_ff + 6'd1;
            end
         end
         qsrq_pkg::OP_SWAP_WR: begin
            // e_rd is the element at mark; hold is the element at k.
            e_we = 1'b1;
            e_wa = AW'(k_ff);
            e_wd = e_rd;
            k_in = k_ff + 6'd1;
         end
         qsrq_pkg::OP_SWAP_MK: begin
            e_we = 1'b1;
            e_wa = AW'(mark_ff);
            e_wd = hold_ff;
            mark_in = mark_ff + 6'd1;
         end
         qsrq_pkg::OP_FIN_RD: begin
            e_ra = AW'(mark_ff);
         end
         qsrq_pkg::OP_FIN_WR: begin
            // Former mark element goes to hi, then the pivot goes to mark.
            if (!push_sel_ff) begin
               e_we = 1'b1;
               e_wa = AW'(hi_ff);
               e_wd = e_rd;
               push_sel_in = 1'b1;
            end else begin
               e_we = 1'b1;
               e_wa = AW'(mark_ff);
               e_wd = pivot_ff;
               push_sel_in = 1'b0;
            end
         end
         qsrq_pkg::OP_PUSH: begin
            if (!push_sel_ff) begin
               if (push_a_ok) begin
                  q_we = 1'b1;
                  q_wd = '{lo: lo_ff, hi: mark_ff - 6'd1};
                  fill_in = fill_ff + 7'd1;
               end
               push_sel_in = 1'b1;
            end else begin
               if (push_b_ok) begin
                  q_we = 1'b1;
                  q_wd = '{lo: mark_ff + 6'd1, hi: hi_ff};
                  fill_in = fill_ff + 7'd1;
               end
               push_sel_in = 1'b0;
            end
         end
         qsrq_pkg::OP_OUT_RD: begin
            e_ra = AW'(k_ff);
         end
         qsrq_pkg::OP_OUT_SHOW: begin
            outv_in = e_rd;
            outl_in = last_now;
            outo_in = ovf_ff;
            k_in = k_ff + 6'd1;
            if (last_now) begin
               count_in = '0;
               ovf_in = 1'b0;
               fill_in = '0;
               head_in = '0;
            end
         end
         qsrq_pkg::OP_IDLE: begin
            k_in = '0;
            push_sel_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff <= 1'b0;
         head_ff <= '0;
         fill_ff <= '0;
         push_sel_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         head_ff <= head_in;
         fill_ff <= fill_in;
         push_sel_ff <= push_sel_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      k_ff <= k_in;
      mark_ff <= mark_in;
      pivot_ff <= pivot_in;
      hold_ff <= hold_in;
      outv_ff <= outv_in;
      outl_ff <= outl_in;
      outo_ff <= outo_in;
   end

   assign status.queue_empty = fill_ff == '0;
   assign status.range_short = lo_ff >= hi_ff;
   assign status.scan_done   = k_ff == hi_ff;
   assign status.scan_le     = le;
   assign status.push_done   = push_sel_ff;
   assign status.out_last    = last_now;
   assign status.count_small = count_ff < CW'(2);
   assign status.count_zero  = count_ff == '0;
   assign out_value    = outv_ff;
   assign out_last     = outl_ff;
   assign out_overflow = outo_ff;
endmodule

// ===== design/qsrq_ctrl.sv =====
module qsrq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic                  in_last,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   input  qsrq_pkg::status_type  status,
   output qsrq_pkg::cmd_type     cmd
);
   typedef enum logic [3:0] {
      S_LOAD, S_START, S_POP, S_RANGE, S_RDPIV, S_CAPT, S_SCAN_RD, S_SCAN_CMP,
      S_SWAP_WR, S_SWAP_MK, S_FIN_RD, S_FIN_WR, S_PUSH, S_OUT_RD, S_OUT_SHOW,
      S_OUT_WAIT
   } state_type;

   state_type state_ff;
   logic      valid_ff;

   // A swap below the mark writes to k first, then to mark.
   always_comb begin
      in_ready  = state_ff == S_LOAD;
      out_valid = valid_ff;
      unique case (state_ff)
         S_LOAD:     cmd.op = (in_valid) ? qsrq_pkg::OP_LOAD : qsrq_pkg::OP_IDLE;
         S_START:    cmd.op = qsrq_pkg::OP_SORT_INIT;
         S_POP:      cmd.op = qsrq_pkg::OP_POP;
         S_RANGE:    cmd.op = qsrq_pkg::OP_RANGE;
         S_RDPIV:    cmd.op = qsrq_pkg::OP_RD_PIVOT;
         S_CAPT:     cmd.op = qsrq_pkg::OP_CAPT_PIVOT;
         S_SCAN_RD:  cmd.op = qsrq_pkg::OP_SCAN_RD;
         S_SCAN_CMP: cmd.op = qsrq_pkg::OP_SCAN_CMP;
         S_SWAP_WR:  cmd.op = qsrq_pkg::OP_SWAP_WR;
         S_SWAP_MK:  cmd.op = qsrq_pkg::OP_SWAP_MK;
         S_FIN_RD:   cmd.op = qsrq_pkg::OP_FIN_RD;
         S_FIN_WR:   cmd.op = qsrq_pkg::OP_FIN_WR;
         S_PUSH:     cmd.op = qsrq_pkg::OP_PUSH;
         S_OUT_RD:   cmd.op = qsrq_pkg::OP_OUT_RD;
         S_OUT_SHOW: cmd.op = qsrq_pkg::OP_OUT_SHOW;
         S_OUT_WAIT: cmd.op = qsrq_pkg::OP_OUT_RD;
         default:    cmd.op = qsrq_pkg::OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_LOAD:     if (in_valid && in_last) state_ff <= S_START;
            S_START:    state_ff <= status.count_small ? S_OUT_RD : S_POP;
            S_POP:      state_ff <= status.queue_empty ? S_OUT_RD : S_RANGE;
            S_RANGE:    state_ff <= S_RDPIV;
            S_RDPIV:    state_ff <= status.range_short ? S_POP : S_CAPT;
            S_CAPT:     state_ff <= status.scan_done ? S_FIN_RD : S_SCAN_CMP;
            S_SCAN_RD:  state_ff <= status.scan_done ? S_FIN_RD : S_SCAN_CMP;
            S_SCAN_CMP: state_ff <= status.scan_le ? S_SWAP_WR : S_SCAN_RD;
            S_SWAP_WR:  state_ff <= S_SWAP_MK;
            S_SWAP_MK:  state_ff <= S_SCAN_RD;
            S_FIN_RD:   state_ff <= S_FIN_WR;
            S_FIN_WR:   if (status.push_done) state_ff <= S_PUSH;
            S_PUSH:     if (status.push_done) state_ff <= S_POP;
            S_OUT_RD:   state_ff <= status.count_zero ? S_LOAD : S_OUT_SHOW;
            S_OUT_SHOW: begin
               valid_ff <= 1'b1;
               state_ff <= S_OUT_WAIT;
            end
            S_OUT_WAIT: if (out_ready) begin
               valid_ff <= 1'b0;
               state_ff <= S_OUT_RD;
            end
            default:    state_ff <= S_LOAD;
         endcase
      end
   end
endmodule

// ===== design/quicksort_range_queue_sorter.sv =====
// Channel | Dir | Fields                                   | Transfer
// req     | in  | value[31:0], last_item                   | valid && ready
// rsp     | out | value_res[31:0], last_item_res, overflow | valid && ready
//
// Loading accepts one transfer per cycle; the input is held off while a run
// is sorted and emitted. Each queued range is popped and its pivot read
// before its elements are scanned; an element no greater than the pivot is
// swapped below the mark. Results go out one at a time, each held until the
// receiver takes it. Reset is synchronous and clears the element count, the
// overflow flag and the range queue pointers; RAM contents are not reset.
module quicksort_range_queue_sorter #(
   parameter int unsigned DEPTH = 64
) (
   input logic   clock,
   input logic   reset,
   qsrq_if.sink   req,
   qsrq_if.source rsp
);
   qsrq_pkg::cmd_type    cmd;
   qsrq_pkg::status_type status;
   logic [31:0]          value_res;
   logic                 last_res, ovf_res;

   qsrq_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_last(req.data[32]), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .status(status), .cmd(cmd));

   qsrq_datapath #(.DEPTH(DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .in_value(req.data[31:0]), .out_value(value_res),
      .out_last(last_res), .out_overflow(ovf_res));

   assign rsp.data = {ovf_res, last_res, value_res};
endmodule

// ===== verif/quicksort_range_queue_sorter_tb.sv =====
module quicksort_range_queue_sorter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned VW = qsrq_pkg::VALUE_W;

   // One element offered to the sorter. The gap is the number of idle cycles
   // the sender inserts after the transfer. The drain flag makes the sender
   // hold this element back until every sorted result so far has come out.
   typedef struct {
      logic [VW-1:0] value;
      bit            last;
      int            gap;
      bit            drain;
   } element_type;

   // One sorted element as the sorter should return it.
   typedef struct {
      logic [VW-1:0] value;
      bit            last;
      bit            overflow;
   } sorted_type;

   localparam int STORE_DEPTH = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qsrq_if #(.W(VW + 1)) req ();
   qsrq_if #(.W(VW + 2)) rsp ();

   quicksort_range_queue_sorter #(.DEPTH(STORE_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   always #1 clock = ~clock;

   element_type pending_elements[$];
   sorted_type  expected_sorted[$];

   // Shadow of the sorter's load store for the run in progress.
   logic signed [VW-1:0] run_values[$];
   bit                   run_overflow;

   int mismatches;
   int results_seen;

   // Called once per accepted element transfer. The store keeps the first
   // STORE_DEPTH elements of a run; any later ones are dropped and mark the
   // run as overflowed. A transfer marked last closes the run, even when the
   // element itself was dropped, and the sorted run becomes expected output.
   task automatic absorb_element(input logic [VW-1:0] value, input bit last);
      logic signed [VW-1:0] key;
      int                   j;
      if (run_values.size() < STORE_DEPTH) begin
         run_values.push_back(value);
      end else begin
         run_overflow = 1'b1;
      end
      if (last) begin
         // Ascending insertion sort; order among equal values cannot be seen.
         for (int i = 1; i < run_values.size(); i++) begin
            key = run_values[i];
            j = i - 1;
            while (j >= 0 && run_values[j] > key) begin
               run_values[j + 1] = run_values[j];
               j--;
            end
            run_values[j + 1] = key;
         end
         foreach (run_values[k]) begin
            expected_sorted.push_back('{run_values[k], k == run_values.size() - 1,
                                       run_overflow});
         end
         run_values.delete();
         run_overflow = 1'b0;
      end
   endtask

   // Most gaps are zero or short; a few are long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(20, 60);
   endfunction

   // Queues one run of n elements. Modes: 0 random words, 1 few distinct
   // values so duplicates are common, 2 ascending, 3 descending.
   task automatic queue_run(input int n, input int mode, input bit drain_first);
      logic [VW-1:0] v;
      logic [VW-1:0] base;
      base = $urandom();
      for (int i = 0; i < n; i++) begin
         case (mode)
            1: begin
               v = $urandom_range(0, 3) - 2;
            end
            2: begin
               v = base + i * 3;
            end
            3: begin
               v = base - i * 5;
            end
            default: begin
               v = $urandom();
            end
         endcase
         pending_elements.push_back('{v, i == n - 1, pick_gap(), drain_first && i == 0});
      end
   endtask

   // Sender. The transfer at this edge is recorded before the next element
   // is put on the channel; valid is assigned at most once per edge.
   int send_gap;

   always @(posedge clock) begin
      element_type it;
      if (reset) begin
         req.valid <= 1'b0;
         req.data  <= '0;
         send_gap  <= 0;
      end else begin
         if (req.valid && req.ready) begin
            absorb_element(req.data[VW-1:0], req.data[VW]);
         end
         if (!req.valid || req.ready) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req.valid <= 1'b0;
            end else if (pending_elements.size() > 0 &&
                         !(pending_elements[0].drain &&
                           (expected_sorted.size() > 0 || run_values.size() > 0))) begin
               it = pending_elements.pop_front();
               req.data  <= {it.last, it.value};
               req.valid <= 1'b1;
               send_gap  <= it.gap;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver. Results are checked at the edge where they transfer. Ready
   // follows random stall lengths, with one long hold early in the run while
   // the sender keeps offering the next run, so the sorter backs up.
   int  hold_cycles;
   bit  long_hold_done;

   always @(posedge clock) begin
      sorted_type exp_item;
      int r;
      if (reset) begin
         rsp.ready      <= 1'b0;
         hold_cycles    <= 0;
         long_hold_done <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            results_seen++;
            if (expected_sorted.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected result value=%0d last=%0b overflow=%0b",
                           $signed(rsp.data[VW-1:0]), rsp.data[VW], rsp.data[VW+1]);
               end
            end else begin
               exp_item = expected_sorted.pop_front();
               if (rsp.data[VW-1:0] !== exp_item.value ||
                   rsp.data[VW] !== exp_item.last ||
                   rsp.data[VW+1] !== exp_item.overflow) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                              $signed(exp_item.value), exp_item.last, exp_item.overflow,
                              $signed(rsp.data[VW-1:0]), rsp.data[VW], rsp.data[VW+1]);
                  end
               end
            end
         end
         if (!long_hold_done && results_seen == 4) begin
            long_hold_done <= 1'b1;
            hold_cycles    <= 3000;
            rsp.ready      <= 1'b0;
         end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp.ready   <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp.ready   <= 1'b1;
               hold_cycles <= 0;
            end else if (r < 95) begin
               rsp.ready   <= 1'b0;
               hold_cycles <= $urandom_range(0, 3);
            end else begin
               rsp.ready   <= 1'b0;
               hold_cycles <= $urandom_range(20, 80);
            end
         end
      end
   end

   initial begin
      int queued;
      mismatches   = 0;
      results_seen = 0;
      run_overflow = 1'b0;

      // Directed runs: field extremes with both last flags, a single element,
      // all-equal values, a duplicate-heavy run and a short descending run.
      pending_elements.push_back('{32'h7FFF_FFFF, 1'b0, 0, 1'b0});
      pending_elements.push_back('{32'h8000_0000, 1'b0, 1, 1'b0});
      pending_elements.push_back('{32'h0000_0000, 1'b0, 0, 1'b0});
      pending_elements.push_back('{32'hFFFF_FFFF, 1'b0, 0, 1'b0});
      pending_elements.push_back('{32'h0000_0001, 1'b0, 2, 1'b0});
      pending_elements.push_back('{32'h8000_0000, 1'b1, 0, 1'b0});
      pending_elements.push_back('{32'h1234_5678, 1'b1, 0, 1'b0});
      for (int i = 0; i < 5; i++) begin
         pending_elements.push_back('{32'hDEAD_BEEF, i == 4, 0, 1'b0});
      end
      queue_run(8, 1, 1'b1);
      queue_run(4, 3, 1'b0);

      // An overflowed run that fills the store and whose last mark rides on
      // a dropped element.
      queue_run(STORE_DEPTH + 3, 2, 1'b1);

      // Random short runs.
      queued = 0;
      while (queued < 12) begin
         int n;
         n = $urandom_range(1, 8);
         queue_run(n, $urandom_range(0, 3), $urandom_range(0, 5) == 0);
         queued += n;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_elements.size() != 0 || req.valid) begin
         @(posedge clock);
      end
      while (expected_sorted.size() != 0) begin
         @(posedge clock);
      end
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_sorted.size() == 0) begin
         $display("quicksort_range_queue_sorter_tb: PASS");
      end else begin
         $display("quicksort_range_queue_sorter_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("quicksort_range_queue_sorter_tb: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
design/qsrq_pkg.sv
design/qsrq_if.sv
design/qsrq_ram.sv
design/qsrq_datapath.sv
design/qsrq_ctrl.sv
design/quicksort_range_queue_sorter.sv
verif/quicksort_range_queue_sorter_tb.sv
